FILE: sv/lrpw_pkg.sv
// ----------------------------------------------------------------------------
// lrpw_pkg
// Types, codes and helpers shared by the line rasterizer pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrpw_pkg;

  localparam int COORD_W    = 16;   // endpoint field width
  localparam int COLOR_W    = 32;
  localparam int SIDE_CFG_W = 13;   // screen_width / screen_height register width
  localparam int PIX_IDX_W  = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SIDE_CFG_W;

  localparam logic [SIDE_CFG_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SIDE_CFG_W-1:0] HEIGHT_RESET = 13'd768;

  // input item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_FORMAT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BUFFER_PRESENT = 2'd3;

  typedef struct packed {
    logic [SIDE_CFG_W-1:0] screen_width;
    logic [SIDE_CFG_W-1:0] screen_height;
    logic                  pixel_format;
    logic                  buffer_present;
  } lrpw_cfg_t;

  // one pixel of the active line, handed from the stepper to the output stage
  typedef struct packed {
    logic                      emit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic [COLOR_W-1:0]        color;
  } lrpw_pix_t;

  function automatic logic [COLOR_W-1:0] rgb565_pack(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    r = ((c >> 8) & 32'h0000_F800) | ((c >> 5) & 32'h0000_07E0) |
        ((c >> 3) & 32'h0000_001F);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lrpw_if.sv
// ----------------------------------------------------------------------------
// lrpw_in_if / lrpw_out_if
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrpw_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [31:0] color;

  modport source (output valid, func, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink   (input valid, func, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface

interface lrpw_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_index;
  logic [31:0] pixel_data;
  logic        write_enable;
  logic        last;

  modport source (output valid, pixel_index, pixel_data, write_enable, last,
                  input ready);
  modport sink   (input valid, pixel_index, pixel_data, write_enable, last,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/lrpw_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrpw_cfg_regs
// Screen geometry, pixel format and buffer-present registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpw_cfg_regs
  import lrpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output lrpw_cfg_t                  cfg
);

  lrpw_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCREEN_WIDTH:   cfg_nxt.screen_width   = cfg_wdata;
        CFG_SCREEN_HEIGHT:  cfg_nxt.screen_height  = cfg_wdata;
        CFG_PIXEL_FORMAT:   cfg_nxt.pixel_format   = cfg_wdata[0];
        CFG_BUFFER_PRESENT: cfg_nxt.buffer_present = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width   <= WIDTH_RESET;
      cfg_r.screen_height  <= HEIGHT_RESET;
      cfg_r.pixel_format   <= 1'b0;
      cfg_r.buffer_present <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/lrpw_stepper.sv
// ----------------------------------------------------------------------------
// lrpw_stepper
// Bresenham line state: endpoint setup on start, one step per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpw_stepper
  import lrpw_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               func,
  input  wire logic [COORD_W-1:0] start_x,
  input  wire logic [COORD_W-1:0] start_y,
  input  wire logic [COORD_W-1:0] end_x,
  input  wire logic [COORD_W-1:0] end_y,
  input  wire logic [COLOR_W-1:0] color,
  output lrpw_pix_t               pix
);

  localparam int D_W = COORD_BITS + 1;
  localparam int E_W = COORD_BITS + 3;

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [COORD_BITS-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic [D_W-1:0]               dx_r, dx_nxt, dy_r, dy_nxt;
  logic                         sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic signed [E_W-1:0]        err_r, err_nxt;
  logic [COLOR_W-1:0]           color_r, color_nxt;

  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [D_W-1:0]               diff_x, diff_y, adx, ady;
  logic signed [E_W-1:0]        dx_s, dy_s, half_dx, half_dy;
  logic                         done, step_x, step_y, emit;

  // endpoints: low COORD_BITS bits as two's complement
  assign x0 = signed'(start_x[COORD_BITS-1:0]);
  assign y0 = signed'(start_y[COORD_BITS-1:0]);
  assign x1 = signed'(end_x[COORD_BITS-1:0]);
  assign y1 = signed'(end_y[COORD_BITS-1:0]);

  assign diff_x  = D_W'(x1) - D_W'(x0);
  assign diff_y  = D_W'(y1) - D_W'(y0);
  assign adx     = (x1 > x0) ? diff_x : D_W'(0) - diff_x;
  assign ady     = (y1 > y0) ? diff_y : D_W'(0) - diff_y;
  assign half_dx = signed'({2'b00, adx >> 1});
  assign half_dy = signed'({2'b00, ady >> 1});

  assign dx_s   = signed'({2'b00, dx_r});
  assign dy_s   = signed'({2'b00, dy_r});
  assign done   = (cx_r == tx_r) && (cy_r == ty_r);
  assign step_x = err_r > -dx_s;
  assign step_y = err_r < dy_s;
  assign emit   = accept && (func == FUNC_STEP) && active_r;

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    if (accept && (func == FUNC_START)) begin
      active_nxt = 1'b1;
      cx_nxt     = x0;
      cy_nxt     = y0;
      tx_nxt     = x1;
      ty_nxt     = y1;
      dx_nxt     = adx;
      dy_nxt     = ady;
      sx_neg_nxt = !(x0 < x1);
      sy_neg_nxt = !(y0 < y1);
      err_nxt    = (adx > ady) ? half_dx : -half_dy;
      color_nxt  = color;
    end else if (emit) begin
      if (done) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_r - (step_x ? dy_s : E_W'(0)) + (step_y ? dx_s : E_W'(0));
        if (step_x) begin
          cx_nxt = sx_neg_r ? cx_r - COORD_BITS'(1) : cx_r + COORD_BITS'(1);
        end
        if (step_y) begin
          cy_nxt = sy_neg_r ? cy_r - COORD_BITS'(1) : cy_r + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    err_r    <= err_nxt;
    color_r  <= color_nxt;
  end

  always_comb begin
    pix.emit  = emit;
    pix.x     = COORD_W'(cx_r);
    pix.y     = COORD_W'(cy_r);
    pix.last  = done;
    pix.color = color_r;
  end

endmodule

`default_nettype wire

FILE: sv/lrpw_pixel_out.sv
// ----------------------------------------------------------------------------
// lrpw_pixel_out
// Clipping, linear address, color packing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrpw_pixel_out
  import lrpw_pkg::*;
#(
  parameter int MAX_SIDE = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lrpw_cfg_t cfg,
  input  wire lrpw_pix_t pix,
  output logic           take_ok,
  lrpw_out_if.source     out_ch
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PROD_W = 2 * SIDE_W;
  localparam int SUM_W  = (PROD_W > PIX_IDX_W) ? PROD_W : PIX_IDX_W;

  logic                 valid_r, valid_nxt;
  logic [PIX_IDX_W-1:0] index_r;
  logic [COLOR_W-1:0]   data_r;
  logic                 we_r;
  logic                 last_r;

  logic [SIDE_W-1:0]    w, h;
  logic [COORD_W-1:0]   x_u, y_u;
  logic                 on;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     sum;
  logic [PIX_IDX_W-1:0] index_c;
  logic [COLOR_W-1:0]   data_c;

  // sides above MAX_SIDE act as MAX_SIDE
  assign w = (cfg.screen_width > SIDE_CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                        : SIDE_W'(cfg.screen_width);
  assign h = (cfg.screen_height > SIDE_CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                         : SIDE_W'(cfg.screen_height);

  assign x_u = unsigned'(pix.x);
  assign y_u = unsigned'(pix.y);
  assign on  = cfg.buffer_present && !pix.x[COORD_W-1] && !pix.y[COORD_W-1] &&
               (x_u < COORD_W'(w)) && (y_u < COORD_W'(h));

  // when on screen, x < w and y < h both fit in SIDE_W bits
  assign prod    = PROD_W'(y_u[SIDE_W-1:0]) * PROD_W'(w);
  assign sum     = SUM_W'(prod) + SUM_W'(x_u[SIDE_W-1:0]);
  assign index_c = on ? sum[PIX_IDX_W-1:0] : '0;
  assign data_c  = cfg.pixel_format ? rgb565_pack(pix.color) : pix.color;

  assign take_ok = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take_ok) begin
      valid_nxt = pix.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && pix.emit) begin
      index_r <= index_c;
      data_r  <= data_c;
      we_r    <= on;
      last_r  <= pix.last;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.pixel_index  = index_r;
  assign out_ch.pixel_data   = data_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.last         = last_r;

endmodule

`default_nettype wire

FILE: sv/line_rasterizer_pixel_writer.sv
// ----------------------------------------------------------------------------
// line_rasterizer_pixel_writer
// Bresenham line generator emitting one framebuffer write per step command on an active line.
// ----------------------------------------------------------------------------
// A start command (func = 0) loads both endpoints and the color and emits
// nothing; each step command (func = 1) emits one pixel of the active line,
// from the first endpoint to the second, with last set on the endpoint. A
// step with no active line emits nothing. One command is accepted per clock:
// the Bresenham state update and the clip/address logic (one 13x13 multiply
// and add) sit between the line state registers and the result register, and
// a pixel appears on the output in the cycle after its step is transferred.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// Configuration writes take effect on the next emitted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_pixel_writer
  import lrpw_pkg::*;
#(
  parameter int MAX_SIDE   = 4096,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  lrpw_in_if.sink                    in_ch,
  lrpw_out_if.source                 out_ch
);

  lrpw_cfg_t cfg;
  lrpw_pix_t pix;
  logic      take_ok;
  logic      in_xfer;

  assign in_ch.ready = take_ok;
  assign in_xfer     = in_ch.valid && take_ok;

  lrpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrpw_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .func    (in_ch.func),
    .start_x (in_ch.start_x),
    .start_y (in_ch.start_y),
    .end_x   (in_ch.end_x),
    .end_y   (in_ch.end_y),
    .color   (in_ch.color),
    .pix     (pix)
  );

  lrpw_pixel_out #(
    .MAX_SIDE (MAX_SIDE)
  ) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .pix     (pix),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
